@@ src/kinetic_window_outlier_span_macros.svh @@
// ----------------------------------------------------------------------------
// Kinetic window outlier span: assertion macros
// Wrappers for the concurrent checks at the end of the top level. They fall
// away to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KINETIC_WINDOW_OUTLIER_SPAN_MACROS_SVH
`define KINETIC_WINDOW_OUTLIER_SPAN_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define KWOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwos check failed");
// Consequent must hold in the cycle after the antecedent.
`define KWOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwos check failed");
`else
`define KWOS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KWOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/kwos_pkg.sv @@
// ----------------------------------------------------------------------------
// kwos_pkg
// Shared types and constants of the kinetic window outlier span block.
// ----------------------------------------------------------------------------
`default_nettype none

package kwos_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W  = 16;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_LOW     = 3'd0,
        CFG_GAP_HIGH    = 3'd1,
        CFG_WIDTH_LOW   = 3'd2,
        CFG_WIDTH_HIGH  = 3'd3,
        CFG_REGION_START = 3'd4,
        CFG_REGION_STOP = 3'd5
    } t_cfg_idx;

    // One sample of a read.
    typedef struct packed {
        logic [SAMPLE_W-1:0] gap_sample;
        logic [SAMPLE_W-1:0] width_sample;
        logic                end_of_read;
    } t_sample;

    // One end-of-read report.
    typedef struct packed {
        logic             span_found;
        logic [REG_W-1:0] span_begin;
        logic [REG_W-1:0] span_end;
        logic             read_too_long;
    } t_span;

    // Control from the sequencer to the window store.
    typedef struct packed {
        logic adv;   // retire the oldest slot and step the pointer
        logic ins;   // write the new sample into the retired slot
        logic clr;   // start a fresh read
    } t_win_ctl;

endpackage

`default_nettype wire

@@ src/kwos_sample_if.sv @@
// ----------------------------------------------------------------------------
// kwos_sample_if
// Valid/ready channel carrying one read sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwos_sample_if;
    import kwos_pkg::*;

    logic    valid;
    logic    ready;
    t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/kwos_span_if.sv @@
// ----------------------------------------------------------------------------
// kwos_span_if
// Valid/ready channel carrying one end-of-read span report per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwos_span_if;
    import kwos_pkg::*;

    logic  valid;
    logic  ready;
    t_span data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/kwos_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kwos_cfg_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwos_cfg_if;
    import kwos_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/kinetic_window_outlier_span.sv @@
// The span report is offered after the transfer of the sample that ends a
// read, the trailing flush, S_LAST and the load of the output register in S_EMIT.
// Throughput: one sample per cycle within a read; after the closing sample the
// input is held off through the flush until the report is loaded in S_EMIT.
// Reset: synchronous, active low; clears control and sums, widens the bands fully.
// The history memory is not swept; a fill count masks unwritten slots.
// ----------------------------------------------------------------------------
// kinetic_window_outlier_span
// Windowed kinetic outlier detector reporting the first and last outlier
// position of each read in the configured region.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kinetic_window_outlier_span_macros.svh"

module kinetic_window_outlier_span #(
    parameter int HALF_WINDOW   = 16,
    parameter int WINDOW_LEN    = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kwos_sample_if.sink   i_sample,
    kwos_span_if.source   o_span,
    kwos_cfg_if.sink      i_cfg
);
    import kwos_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int BND_W = SUM_W + 1;
    localparam int CNT_W = POSITION_BITS + 1;
    localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam int T_W   = $clog2(HALF_WINDOW + 1);
    localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(1) << POSITION_BITS;
    localparam logic [CNT_W-1:0] COUNT_CAP = POS_LIMIT + CNT_W'(HALF_WINDOW);
    localparam logic [CNT_W-1:0] HALF_C    = CNT_W'(HALF_WINDOW);

    typedef enum logic [3:0] {
        S_RUN   = 4'b0001,
        S_FLUSH = 4'b0010,
        S_LAST  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Bounds are held pre-multiplied by the window length, so a mean test
    // becomes a plain compare on the window sum.
    logic [BND_W-1:0] r_gap_lo, r_gap_hi, r_width_lo, r_width_hi;
    logic [REG_W-1:0] r_region_start, r_region_stop;

    logic [CNT_W-1:0]         r_count, n_count;
    logic [T_W-1:0]           r_t, n_t;
    logic                     r_jv, n_jv;
    logic [CNT_W-1:0]         r_jpos, n_jpos;
    logic                     r_found;
    logic [POSITION_BITS-1:0] r_first, r_last;
    logic                     r_out_valid;
    t_span                    r_out;

    logic             s_accept;
    logic             s_load;
    t_win_ctl         win_ctl;
    logic [SUM_W-1:0] gap_sum, width_sum;
    logic [CNT_W-1:0] run_count;
    logic [CNT_W-1:0] flush_sum;
    logic             in_region;
    logic             outlier;
    logic             hit;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = (r_state == S_RUN);
    assign s_accept       = i_sample.valid && i_sample.ready;
    assign s_load         = (r_state == S_EMIT) && (!r_out_valid || o_span.ready);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_lo       <= '0;
            r_gap_hi       <= (BND_W'(1) << SAMPLE_W) * BND_W'(WINDOW_LEN);
            r_width_lo     <= '0;
            r_width_hi     <= (BND_W'(1) << SAMPLE_W) * BND_W'(WINDOW_LEN);
            r_region_start <= '0;
            r_region_stop  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GAP_LOW: begin
                    r_gap_lo <= BND_W'(i_cfg.data) * BND_W'(WINDOW_LEN);
                end
                CFG_GAP_HIGH: begin
                    r_gap_hi <= (BND_W'(i_cfg.data) + BND_W'(1)) * BND_W'(WINDOW_LEN);
                end
                CFG_WIDTH_LOW: begin
                    r_width_lo <= BND_W'(i_cfg.data) * BND_W'(WINDOW_LEN);
                end
                CFG_WIDTH_HIGH: begin
                    r_width_hi <= (BND_W'(i_cfg.data) + BND_W'(1)) * BND_W'(WINDOW_LEN);
                end
                CFG_REGION_START: begin
                    r_region_start <= i_cfg.data;
                end
                CFG_REGION_STOP: begin
                    r_region_stop <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Window store.
    always_comb begin
        win_ctl.adv = s_accept || (r_state == S_FLUSH);
        win_ctl.ins = s_accept;
        win_ctl.clr = s_load;
    end

    kwos_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (win_ctl),
        .i_gap       (i_sample.data.gap_sample),
        .i_width     (i_sample.data.width_sample),
        .o_gap_sum   (gap_sum),
        .o_width_sum (width_sum)
    );

    // Sample counting and selection of the position judged next cycle.
    assign run_count = (r_count < COUNT_CAP) ? r_count + CNT_W'(1) : r_count;
    assign flush_sum = r_count + CNT_W'(r_t);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_t     = r_t;
        n_jv    = 1'b0;
        n_jpos  = r_jpos;
        case (r_state)
            S_RUN: begin
                if (s_accept) begin
                    n_count = run_count;
                    n_jv    = (run_count > HALF_C);
                    n_jpos  = run_count - CNT_W'(1) - HALF_C;
                    if (i_sample.data.end_of_read) begin
                        n_state = S_FLUSH;
                        n_t     = '0;
                    end
                end
            end
            S_FLUSH: begin
                n_jv   = (flush_sum >= HALF_C);
                n_jpos = flush_sum - HALF_C;
                n_t    = r_t + T_W'(1);
                if (r_t == T_W'(HALF_WINDOW - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (s_load) begin
                    n_state = S_RUN;
                    n_count = '0;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // Judge the registered position against region and bands.
    assign in_region = r_jv && (r_jpos < POS_LIMIT)
                    && (CMP_W'(r_jpos) >= CMP_W'(r_region_start))
                    && (CMP_W'(r_jpos) < CMP_W'(r_region_stop));
    assign outlier   = (BND_W'(gap_sum) < r_gap_lo) || (BND_W'(gap_sum) >= r_gap_hi)
                    || (BND_W'(width_sum) < r_width_lo)
                    || (BND_W'(width_sum) >= r_width_hi);
    assign hit       = in_region && outlier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_count <= '0;
            r_t     <= '0;
            r_jv    <= 1'b0;
            r_found <= 1'b0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_t     <= n_t;
            r_jv    <= n_jv;
            if (s_load) begin
                r_found <= 1'b0;
                r_first <= '0;
                r_last  <= '0;
            end else if (hit) begin
                r_found <= 1'b1;
                if (!r_found) begin
                    r_first <= r_jpos[POSITION_BITS-1:0];
                end
                r_last <= r_jpos[POSITION_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jpos <= n_jpos;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out.span_found    <= r_found;
            r_out.span_begin    <= REG_W'(r_first);
            r_out.span_end      <= REG_W'(r_last);
            r_out.read_too_long <= (r_count > POS_LIMIT);
        end
    end

    assign o_span.valid = r_out_valid;
    assign o_span.data  = r_out;

    // Checks.
    `KWOS_ASSERT_NEXT(a_eor_starts_flush, i_clk, i_rst_n,
        s_accept && i_sample.data.end_of_read, r_state == S_FLUSH)
    `KWOS_ASSERT_NEXT(a_flush_length, i_clk, i_rst_n,
        (r_state == S_FLUSH) && (r_t == T_W'(HALF_WINDOW - 1)), r_state == S_LAST)
    `KWOS_ASSERT_NEXT(a_report_only_from_emit, i_clk, i_rst_n,
        !r_out_valid && (r_state != S_EMIT), !r_out_valid)
    `KWOS_ASSERT_SAME(a_empty_span_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.span_found,
        (r_out.span_begin == '0) && (r_out.span_end == '0))

endmodule

`default_nettype wire

@@ src/kwos_window.sv @@
// ----------------------------------------------------------------------------
// kwos_window
// Circular sample history in one synchronous memory, with the running gap and
// width window sums kept by read-modify-write of the oldest slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kwos_window #(
    parameter int WINDOW_LEN = 32,
    parameter int SUM_W      = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire kwos_pkg::t_win_ctl            i_ctl,
    input  wire logic [kwos_pkg::SAMPLE_W-1:0] i_gap,
    input  wire logic [kwos_pkg::SAMPLE_W-1:0] i_width,
    output logic      [SUM_W-1:0]              o_gap_sum,
    output logic      [SUM_W-1:0]              o_width_sum
);
    import kwos_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int WORD_W = 2 * SAMPLE_W;

    logic [WORD_W-1:0] mem [WINDOW_LEN];

    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SUM_W-1:0]    r_gap_sum, n_gap_sum;
    logic [SUM_W-1:0]    r_width_sum, n_width_sum;
    logic [WORD_W-1:0]   r_rd_data;
    logic                old_valid;
    logic [SAMPLE_W-1:0] old_gap, old_width;
    logic [SAMPLE_W-1:0] add_gap, add_width;

    // The slot at the pointer holds the oldest sample only once the ring has
    // been filled in this read; before that it reads as empty.
    assign old_valid = (r_fill == FILL_W'(WINDOW_LEN));
    assign old_gap   = old_valid ? r_rd_data[WORD_W-1:SAMPLE_W] : '0;
    assign old_width = old_valid ? r_rd_data[SAMPLE_W-1:0] : '0;
    assign add_gap   = i_ctl.ins ? i_gap : '0;
    assign add_width = i_ctl.ins ? i_width : '0;

    // Pointer, fill count and sum updates.
    always_comb begin
        n_ptr       = r_ptr;
        n_fill      = r_fill;
        n_gap_sum   = r_gap_sum;
        n_width_sum = r_width_sum;
        if (i_ctl.clr) begin
            n_ptr       = '0;
            n_fill      = '0;
            n_gap_sum   = '0;
            n_width_sum = '0;
        end else if (i_ctl.adv) begin
            n_ptr = (r_ptr == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_ptr + PTR_W'(1);
            if (!old_valid) begin
                n_fill = r_fill + FILL_W'(1);
            end
            n_gap_sum   = r_gap_sum - SUM_W'(old_gap) + SUM_W'(add_gap);
            n_width_sum = r_width_sum - SUM_W'(old_width) + SUM_W'(add_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_fill      <= '0;
            r_gap_sum   <= '0;
            r_width_sum <= '0;
        end else begin
            r_ptr       <= n_ptr;
            r_fill      <= n_fill;
            r_gap_sum   <= n_gap_sum;
            r_width_sum <= n_width_sum;
        end
    end

    // History memory. The read always prefetches the slot the pointer moves
    // to, which is never the slot written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && i_ctl.ins && !i_ctl.clr) begin
            mem[r_ptr] <= {i_gap, i_width};
        end
        r_rd_data <= mem[n_ptr];
    end

    assign o_gap_sum   = r_gap_sum;
    assign o_width_sum = r_width_sum;

endmodule

`default_nettype wire

@@ sim/kinetic_window_outlier_span_checker.sv @@
// ----------------------------------------------------------------------------
// Kinetic window outlier span checker
// Watches the sample, span and register channels of the block. It keeps its
// own copy of the sliding window, the region and the band registers, works
// out the span report of every read whose closing sample is transferred, and
// compares each transferred report with the oldest one still owed.
// ----------------------------------------------------------------------------

module kinetic_window_outlier_span_checker #(
    parameter int HALF_WINDOW   = 16,
    parameter int WINDOW_LEN    = 32,
    parameter int POSITION_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kwos_sample_if    i_sample,
    kwos_span_if      i_span,
    kwos_cfg_if       i_cfg,
    output int        o_mismatches,
    output int        o_pending
);
    import kwos_pkg::*;

    localparam int unsigned POS_LIMIT = 1 << POSITION_BITS;
    localparam int unsigned COUNT_CAP = POS_LIMIT + HALF_WINDOW;
    localparam int          SUM_W     = SAMPLE_W + $clog2(WINDOW_LEN);

    // Band and region registers.
    logic [REG_W-1:0] gap_low, gap_high, width_low, width_high;
    logic [REG_W-1:0] region_start, region_stop;

    // Sliding window over the current read.
    logic [SAMPLE_W-1:0] gap_hist [WINDOW_LEN];
    logic [SAMPLE_W-1:0] width_hist [WINDOW_LEN];
    int unsigned         oldest_slot;
    logic [SUM_W-1:0]    gap_sum, width_sum;
    int unsigned         samples_seen;
    logic                hit_seen;
    logic [REG_W-1:0]    first_hit, last_hit;

    // Span reports owed by the block, oldest first.
    t_span expected_spans [$];
    int    reads_checked;

    // Forget everything about the read in progress.
    function automatic void start_new_read();
        for (int k = 0; k < WINDOW_LEN; k++) begin
            gap_hist[k]   = '0;
            width_hist[k] = '0;
        end
        oldest_slot  = 0;
        gap_sum      = '0;
        width_sum    = '0;
        samples_seen = 0;
        hit_seen     = 1'b0;
        first_hit    = '0;
        last_hit     = '0;
    endfunction

    // Decide whether one position is an outlier inside the region.
    function automatic void judge_position(input int unsigned pos);
        logic [REG_W-1:0] gap_mean, width_mean;
        if (pos >= POS_LIMIT || pos < region_start || pos >= region_stop) begin
            return;
        end
        gap_mean   = REG_W'(gap_sum / WINDOW_LEN);
        width_mean = REG_W'(width_sum / WINDOW_LEN);
        if (gap_mean < gap_low || gap_mean > gap_high ||
            width_mean < width_low || width_mean > width_high) begin
            if (!hit_seen) begin
                hit_seen  = 1'b1;
                first_hit = REG_W'(pos);
            end
            last_hit = REG_W'(pos);
        end
    endfunction

    // Slide the window by one slot, replacing the oldest sample.
    function automatic void slide_window(input logic [SAMPLE_W-1:0] gap_v,
                                         input logic [SAMPLE_W-1:0] width_v);
        gap_sum   = gap_sum - gap_hist[oldest_slot] + gap_v;
        width_sum = width_sum - width_hist[oldest_slot] + width_v;
        gap_hist[oldest_slot]   = gap_v;
        width_hist[oldest_slot] = width_v;
        oldest_slot = (oldest_slot + 1) % WINDOW_LEN;
    endfunction

    // Take one transferred sample; a closing sample flushes the trailing
    // half window and queues the span report of the read.
    function automatic void absorb_sample(input t_sample item);
        t_span report;
        slide_window(item.gap_sample, item.width_sample);
        if (samples_seen < COUNT_CAP) begin
            samples_seen++;
        end
        if (samples_seen > HALF_WINDOW) begin
            judge_position(samples_seen - 1 - HALF_WINDOW);
        end
        if (item.end_of_read) begin
            for (int unsigned t = 0; t < HALF_WINDOW; t++) begin
                slide_window('0, '0);
                if (samples_seen + t >= HALF_WINDOW) begin
                    judge_position(samples_seen + t - HALF_WINDOW);
                end
            end
            report.span_found    = hit_seen;
            report.span_begin    = hit_seen ? first_hit : '0;
            report.span_end      = hit_seen ? last_hit : '0;
            report.read_too_long = (samples_seen > POS_LIMIT);
            expected_spans.push_back(report);
            start_new_read();
        end
    endfunction

    // Register write; unmapped indexes leave every register alone.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [REG_W-1:0] value);
        case (idx)
            CFG_GAP_LOW:      gap_low = value;
            CFG_GAP_HIGH:     gap_high = value;
            CFG_WIDTH_LOW:    width_low = value;
            CFG_WIDTH_HIGH:   width_high = value;
            CFG_REGION_START: region_start = value;
            CFG_REGION_STOP:  region_stop = value;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t, read %0d: %s", $realtime, reads_checked, msg);
        o_mismatches++;
    endtask

    // Compare one transferred report with the oldest one owed.
    task automatic check_span(input t_span got);
        t_span want;
        if (expected_spans.size() == 0) begin
            report_mismatch($sformatf("unexpected report found=%0d begin=%0d end=%0d long=%0d",
                got.span_found, got.span_begin, got.span_end, got.read_too_long));
        end else begin
            want = expected_spans.pop_front();
            if (got.span_found !== want.span_found)
                report_mismatch($sformatf("span_found %0d, expected %0d",
                    got.span_found, want.span_found));
            if (got.span_begin !== want.span_begin)
                report_mismatch($sformatf("span_begin %0d, expected %0d",
                    got.span_begin, want.span_begin));
            if (got.span_end !== want.span_end)
                report_mismatch($sformatf("span_end %0d, expected %0d",
                    got.span_end, want.span_end));
            if (got.read_too_long !== want.read_too_long)
                report_mismatch($sformatf("read_too_long %0d, expected %0d",
                    got.read_too_long, want.read_too_long));
        end
        reads_checked++;
    endtask

    // Follow every transfer on the three channels.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gap_low       = '0;
            gap_high      = '1;
            width_low     = '0;
            width_high    = '1;
            region_start  = '0;
            region_stop   = '0;
            start_new_read();
            expected_spans.delete();
            reads_checked = 0;
            o_mismatches  = 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                apply_register(i_cfg.index, i_cfg.data);
            end
            if (i_span.valid && i_span.ready) begin
                check_span(i_span.data);
            end
            if (i_sample.valid && i_sample.ready) begin
                absorb_sample(i_sample.data);
            end
            o_pending <= expected_spans.size();
        end
    end

endmodule

@@ sim/kinetic_window_outlier_span_test.sv @@
// ----------------------------------------------------------------------------
// Kinetic window outlier span testbench
// Drives reads of kinetic samples into the block with random gaps on the
// sample channel and random back-pressure on the report channel, reprograms
// the band and region registers between groups of reads, and leaves the
// checking of every span report to the checker beside the block.
// ----------------------------------------------------------------------------

module kinetic_window_outlier_span_test;
    import kwos_pkg::*;

    localparam int HALF_WINDOW   = 16;
    localparam int WINDOW_LEN    = 32;
    localparam int POSITION_BITS = 16;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_SAMPLES = 150;
    localparam int SETTLE_CYCLES = HALF_WINDOW + 4;

    // Indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    int   hold_requests = 0;
    int   mismatch_count;
    int   spans_pending;

    kwos_sample_if sample_ch ();
    kwos_span_if   span_ch ();
    kwos_cfg_if    cfg_ch ();

    kinetic_window_outlier_span #(
        .HALF_WINDOW  (HALF_WINDOW),
        .WINDOW_LEN   (WINDOW_LEN),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(sample_ch),
        .o_span  (span_ch),
        .i_cfg   (cfg_ch)
    );

    kinetic_window_outlier_span_checker #(
        .HALF_WINDOW  (HALF_WINDOW),
        .WINDOW_LEN   (WINDOW_LEN),
        .POSITION_BITS(POSITION_BITS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_ch),
        .i_span      (span_ch),
        .i_cfg       (cfg_ch),
        .o_mismatches(mismatch_count),
        .o_pending   (spans_pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Report receiver: random back-pressure, plus a long hold-off on request.
    initial begin : receiver
        int seen_requests;
        int hold_left;
        seen_requests = 0;
        hold_left     = 0;
        span_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != seen_requests) begin
                seen_requests = hold_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                span_ch.ready <= 1'b0;
            end else begin
                span_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one sample, with random gaps before it, until it is transferred.
    task automatic send_sample(input logic [SAMPLE_W-1:0] gap_v,
                               input logic [SAMPLE_W-1:0] width_v,
                               input logic last_v);
        t_sample item;
        item.gap_sample   = gap_v;
        item.width_sample = width_v;
        item.end_of_read  = last_v;
        if ($urandom_range(99) < tx_idle_pct) begin
            sample_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= item;
        do @(posedge i_clk); while (!sample_ch.ready);
    endtask

    // Let every owed report arrive, then let the block settle.
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (spans_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [REG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Write all six registers while the block is idle; a write to an unmapped
    // index comes last so that a wrong decode would corrupt a live register.
    task automatic program_registers(input logic [REG_W-1:0] gl, input logic [REG_W-1:0] gh,
                                     input logic [REG_W-1:0] wl, input logic [REG_W-1:0] wh,
                                     input logic [REG_W-1:0] rs, input logic [REG_W-1:0] re);
        wait_idle();
        write_register(CFG_GAP_LOW, gl);
        write_register(CFG_GAP_HIGH, gh);
        write_register(CFG_WIDTH_LOW, wl);
        write_register(CFG_WIDTH_HIGH, wh);
        write_register(CFG_REGION_START, rs);
        write_register(CFG_REGION_STOP, re);
        write_register(($urandom_range(1) != 0) ? CFG_UNMAPPED_B : CFG_UNMAPPED_A,
                       REG_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Random bands and region; some bands inverted, some regions empty.
    task automatic program_random_registers();
        logic [REG_W-1:0] gl, gh, wl, wh, rs, re;
        if ($urandom_range(7) == 0) begin
            gl = REG_W'($urandom_range(5000, 1000));
            gh = REG_W'($urandom_range(gl - 1));
        end else begin
            gl = REG_W'($urandom_range(4000));
            gh = REG_W'(gl + $urandom_range(8000));
        end
        if ($urandom_range(7) == 0) begin
            wl = REG_W'($urandom_range(5000, 1000));
            wh = REG_W'($urandom_range(wl - 1));
        end else begin
            wl = REG_W'($urandom_range(4000));
            wh = REG_W'(wl + $urandom_range(8000));
        end
        rs = REG_W'($urandom_range(20));
        case ($urandom_range(7))
            0:       re = REG_W'($urandom_range(rs));
            1:       re = '1;
            default: re = REG_W'(rs + $urandom_range(100, 1));
        endcase
        program_registers(gl, gh, wl, wh, rs, re);
    endtask

    // One read of random length: a level with jitter and a burst of extreme
    // values, or now and then pure noise.
    task automatic send_random_read(output int unsigned sent);
        int unsigned len, gap_base, width_base, burst_at, burst_len, burst_kind, i;
        logic [SAMPLE_W-1:0] gap_v, width_v, burst_v;
        logic noisy, in_burst;
        len        = ($urandom_range(7) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        noisy      = ($urandom_range(9) == 0);
        gap_base   = $urandom_range(12000);
        width_base = $urandom_range(12000);
        burst_at   = $urandom_range(len - 1);
        burst_len  = $urandom_range(24);
        burst_kind = $urandom_range(2);
        burst_v    = ($urandom_range(1) != 0) ? '1 : '0;
        for (i = 0; i < len; i++) begin
            in_burst = (i >= burst_at && i < burst_at + burst_len);
            if (noisy) begin
                gap_v   = SAMPLE_W'($urandom);
                width_v = SAMPLE_W'($urandom);
            end else begin
                gap_v   = SAMPLE_W'(gap_base + $urandom_range(2000));
                width_v = SAMPLE_W'(width_base + $urandom_range(2000));
                if (in_burst && burst_kind != 1) gap_v = burst_v;
                if (in_burst && burst_kind != 0) width_v = burst_v;
            end
            send_sample(gap_v, width_v, i == len - 1);
        end
        sent = len;
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned total, sent;
        program_random_registers();
        total = 0;
        while (total < target) begin
            send_random_read(sent);
            total += sent;
        end
    endtask

    // Stimulus.
    initial begin : stimulus
        int i;
        i_rst_n          = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.data   = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_GAP_LOW;
        cfg_ch.data      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender rarely idle, receiver mostly stalled.
        tx_idle_pct = 16;
        rx_idle_pct = 69;

        // Registers at their reset values: the region is empty.
        send_sample('1, '1, 1'b1);

        // Inverted gap band over the whole range: every position is an
        // outlier, position zero included.
        program_registers(16'd1, 16'd0, 16'd0, '1, 16'd0, '1);
        for (i = 0; i < 5; i++) send_sample((i % 2 != 0) ? '1 : '0, '0, i == 4);

        // Widest bands: nothing can leave them, even at the extremes.
        program_registers('0, '1, '0, '1, '0, '1);
        send_sample('1, '1, 1'b0);
        send_sample('0, '0, 1'b1);

        // Narrow gap band over a small region with alternating extremes.
        program_registers(16'd0, 16'd1000, 16'd500, '1, 16'd2, 16'd12);
        for (i = 0; i < 16; i++) send_sample((i % 2 != 0) ? '1 : '0, 16'h5A5A, i == 15);

        // Reversed region: nothing is examined despite an inverted band.
        program_registers(16'd1, 16'd0, 16'd0, '1, 16'd10, 16'd5);
        send_sample('1, '0, 1'b0);
        send_sample('0, '1, 1'b1);

        random_phase(PHASE_SAMPLES);
        random_phase(PHASE_SAMPLES);

        // Sender mostly idle, receiver rarely stalled.
        tx_idle_pct = 69;
        rx_idle_pct = 16;
        random_phase(PHASE_SAMPLES);
        random_phase(PHASE_SAMPLES);

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(PHASE_SAMPLES);
        random_phase(PHASE_SAMPLES);

        // Hold the report channel for a long stretch while short reads keep
        // coming, so the block fills up and stalls its sample input.
        program_random_registers();
        hold_requests <= hold_requests + 1;
        for (i = 0; i < 60; i++) begin
            send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom), i % 2 != 0);
        end

        wait_idle();
        if (mismatch_count == 0 && spans_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
